FILE: rtl/rcsn_pkg.sv
// Package for the RC-swept noise source: sequencer and channel types,
// register indexes, reset values and fixed widths.
// No dependencies; compile before the rtl modules.
package rcsn_pkg;

   // Widths of the fixed datapath fields
   localparam int LEVEL_W = 15;
   localparam int RATE_W  = 18;
   localparam int COEF_W  = 16;
   localparam int DVD_W   = 23;
   localparam int NDVD_W  = 14;
   localparam int STEPS_W = 15;
   localparam int CNT_W   = 5;

   localparam logic [LEVEL_W-1:0] LEVEL_MAX = 15'd32767;

   // Control latch bits
   localparam int LATCH_A_DISCHARGE = 6;
   localparam int LATCH_B_CHARGE    = 7;

   // Register indexes on the csr port
   typedef logic [2:0] csr_idx_type;
   localparam csr_idx_type CSR_SAMPLE_RATE   = 3'd0;
   localparam csr_idx_type CSR_A_DISCHARGE   = 3'd1;
   localparam csr_idx_type CSR_A_CHARGE      = 3'd2;
   localparam csr_idx_type CSR_B_CHARGE      = 3'd3;
   localparam csr_idx_type CSR_B_DISCHARGE   = 3'd4;
   localparam csr_idx_type CSR_NOISE_BASE    = 3'd5;
   localparam csr_idx_type CSR_NOISE_SPAN    = 3'd6;
   localparam csr_idx_type CSR_HOLD_FREQ     = 3'd7;

   // Register reset values
   localparam logic [17:0] RST_SAMPLE_RATE = 18'd48000;
   localparam logic [15:0] RST_A_DISCHARGE = 16'd1882;
   localparam logic [15:0] RST_A_CHARGE    = 16'd28306;
   localparam logic [15:0] RST_B_CHARGE    = 16'd28306;
   localparam logic [15:0] RST_B_DISCHARGE = 16'd801;
   localparam logic [9:0]  RST_NOISE_BASE  = 10'd588;
   localparam logic [12:0] RST_NOISE_SPAN  = 13'd6325;
   localparam logic [12:0] RST_HOLD_FREQ   = 13'd400;

   // Divider iteration counts: level channels and noise channel
   localparam logic [CNT_W-1:0] DIV_ITER_LEVEL = 5'd23;
   localparam logic [CNT_W-1:0] DIV_ITER_NOISE = 5'd14;

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_MUL   = 8'b0000_0010,
      ST_SUB   = 8'b0000_0100,
      ST_DIV   = 8'b0000_1000,
      ST_APPLY = 8'b0001_0000,
      ST_STEP  = 8'b0010_0000,
      ST_HOLD  = 8'b0100_0000,
      ST_OUT   = 8'b1000_0000
   } state_type;

   typedef enum logic [1:0] {
      CH_A = 2'd0,
      CH_B = 2'd1,
      CH_N = 2'd2
   } ch_type;

endpackage

FILE: rtl/rc_swept_lfsr_noise_source_unit.sv
// RC-swept LFSR noise source: top level with sequencer and shared
// multiply / subtract / restoring-divide datapath. Depends on rcsn_pkg.
//
// Usage:
//  - req channel: one request per output sample tick, carrying the control
//    latch byte (bit 6 discharges capacitor A, bit 7 charges capacitor B).
//  - rsp channel: one 15-bit sample per request, in request order.
//  - csr channel: register index and write data; always ready. Write only
//    while the block is idle.
// Sequence: a request is taken only in the idle state. It then runs through
// three passes of one shared unit (capacitor A, capacitor B, noise clock),
// each a multiply, a subtract and a one-bit-per-cycle restoring divide
// against the sample rate (23 iterations for a level, 14 for the noise
// clock), then one step of the noise register per noise clock edge in the
// tick (up to about 9200 at very low sample rates) and one hold update. A
// level already at its rail, or a counter that does not underflow, skips its
// divide and shortens the request.
// Reset clears all levels, counters and the noise register and loads the
// register reset values. A stalled receiver holds the finished sample in
// the output register; the next request is taken meanwhile and its result
// waits until the output register frees up.
module rc_swept_lfsr_noise_source_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [7:0]            req_control_latch,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [14:0]           rsp_sample,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  rcsn_pkg::csr_idx_type csr_index,
   input  logic [17:0]           csr_wdata
);
   import rcsn_pkg::*;

   // Configuration registers
   logic [17:0] sample_rate_ff;
   logic [15:0] a_dis_rate_ff, a_chg_rate_ff, b_chg_rate_ff, b_dis_rate_ff;
   logic [9:0]  noise_base_ff;
   logic [12:0] noise_span_ff, hold_freq_ff;

   // Sequencer
   state_type state_ff, state_in;
   ch_type    ch_ff, ch_in;
   logic      up_a_ff, up_a_in, up_b_ff, up_b_in;

   // Block state
   logic [LEVEL_W-1:0] level_a_ff, level_a_in, level_b_ff, level_b_in;
   logic [RATE_W-1:0]  count_a_ff, count_a_in, count_b_ff, count_b_in;
   logic [RATE_W-1:0]  noise_count_ff, noise_count_in;
   logic [17:0]        shift_ff, shift_in, step_idx_ff, step_idx_in;
   logic               noise_bit_ff, noise_bit_in, held_bit_ff, held_bit_in;
   logic [31:0]        hold_count_ff, hold_count_in;

   // Shared unit registers
   logic [30:0]        prod_ff, prod_in;
   logic [RATE_W-1:0]  div_rem_ff, div_rem_in;
   logic [DVD_W-1:0]   div_dvd_ff, div_dvd_in, div_quot_ff, div_quot_in;
   logic [CNT_W-1:0]   div_cnt_ff, div_cnt_in;
   logic [STEPS_W-1:0] steps_ff, steps_in;

   // Output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [14:0]        rsp_sample_ff, rsp_sample_in;

   // Combinational datapath
   logic [RATE_W-1:0]  sr_eff;
   logic [LEVEL_W-1:0] va, vb, mean;
   logic               cur_up;
   logic [LEVEL_W-1:0] cur_lvl, rail_gap, lvl_next;
   logic [COEF_W-1:0]  cur_coef, mul_a;
   logic [LEVEL_W-1:0] mul_b;
   logic [30:0]        mul_p;
   logic [RATE_W-1:0]  cur_count, new_count;
   logic [DVD_W-1:0]   dec;
   logic [24:0]        diff, neg_full;
   logic               c_pos;
   logic [18:0]        div_tmp, div_sub;
   logic               div_ge;
   logic [23:0]        n_val;
   logic               fb;
   logic [17:0]        sh_step, idx_step;
   logic [31:0]        hc_dec;
   logic [15:0]        out_sum;

   assign csr_ready  = 1'b1;
   assign req_ready  = (state_ff == ST_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_sample = rsp_sample_ff;

   always_comb begin
      sr_eff = (sample_rate_ff == '0) ? 18'd1 : sample_rate_ff;
      va     = ~level_a_ff;               // 32767 - level_a
      vb     = level_b_ff;
      mean   = LEVEL_W'((16'(va) + 16'(vb)) >> 1);

      // Select the level channel in work
      cur_up   = (ch_ff == CH_A) ? up_a_ff : up_b_ff;
      cur_lvl  = (ch_ff == CH_A) ? level_a_ff : level_b_ff;
      if (ch_ff == CH_A) begin
         cur_coef = up_a_ff ? a_chg_rate_ff : a_dis_rate_ff;
      end else begin
         cur_coef = up_b_ff ? b_chg_rate_ff : b_dis_rate_ff;
      end
      rail_gap = cur_up ? ~cur_lvl : cur_lvl;

      unique case (ch_ff)
         CH_A:    cur_count = count_a_ff;
         CH_B:    cur_count = count_b_ff;
         CH_N:    cur_count = noise_count_ff;
         default: cur_count = noise_count_ff;
      endcase

      // Shared multiplier
      mul_a = (ch_ff == CH_N) ? COEF_W'(noise_span_ff) : cur_coef;
      mul_b = (ch_ff == CH_N) ? mean : rail_gap;
      mul_p = 31'(mul_a) * 31'(mul_b);

      // Counter decrement and underflow test
      dec = (ch_ff == CH_N) ? (DVD_W'(noise_base_ff) + DVD_W'(prod_ff[30:15]))
                            : prod_ff[30:8];
      diff     = 25'(cur_count) - 25'(dec);
      c_pos    = !diff[24] && (diff != '0);
      neg_full = 25'd0 - diff;

      // Restoring divide step
      div_tmp = {div_rem_ff, div_dvd_ff[DVD_W-1]};
      div_ge  = (div_tmp >= {1'b0, sr_eff});
      div_sub = div_tmp - {1'b0, sr_eff};

      // Reload: n = quotient + 1, counter = rate - remainder
      n_val     = 24'(div_quot_ff) + 24'd1;
      new_count = sr_eff - div_rem_ff;
      if (n_val >= 24'(rail_gap)) begin
         lvl_next = cur_up ? LEVEL_MAX : '0;
      end else begin
         lvl_next = cur_up ? (cur_lvl + n_val[LEVEL_W-1:0])
                           : (cur_lvl - n_val[LEVEL_W-1:0]);
      end

      // Noise register step; restart from zero when the step index wraps
      fb       = (shift_ff[16] == shift_ff[17]);
      idx_step = step_idx_ff + 18'd1;
      sh_step  = (idx_step == '0) ? '0 : {shift_ff[16:0], fb};

      hc_dec  = hold_count_ff - 32'(hold_freq_ff);
      out_sum = (noise_bit_ff ? 16'd0 : 16'(va)) + (held_bit_ff ? 16'd0 : 16'(vb));
   end

   always_comb begin
      state_in       = state_ff;
      ch_in          = ch_ff;
      up_a_in        = up_a_ff;
      up_b_in        = up_b_ff;
      level_a_in     = level_a_ff;
      level_b_in     = level_b_ff;
      count_a_in     = count_a_ff;
      count_b_in     = count_b_ff;
      noise_count_in = noise_count_ff;
      shift_in       = shift_ff;
      step_idx_in    = step_idx_ff;
      noise_bit_in   = noise_bit_ff;
      held_bit_in    = held_bit_ff;
      hold_count_in  = hold_count_ff;
      prod_in        = prod_ff;
      div_rem_in     = div_rem_ff;
      div_dvd_in     = div_dvd_ff;
      div_quot_in    = div_quot_ff;
      div_cnt_in     = div_cnt_ff;
      steps_in       = steps_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_sample_in  = rsp_sample_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               up_a_in  = !req_control_latch[LATCH_A_DISCHARGE];
               up_b_in  = req_control_latch[LATCH_B_CHARGE];
               ch_in    = CH_A;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in = mul_p;
            // Skip a level that already sits on its rail
            if (ch_ff != CH_N && rail_gap == '0) begin
               ch_in    = (ch_ff == CH_A) ? CH_B : CH_N;
               state_in = ST_MUL;
            end else begin
               state_in = ST_SUB;
            end
         end
         ST_SUB: begin
            if (c_pos) begin
               unique case (ch_ff)
                  CH_A:    count_a_in     = diff[RATE_W-1:0];
                  CH_B:    count_b_in     = diff[RATE_W-1:0];
                  CH_N:    noise_count_in = diff[RATE_W-1:0];
                  default: noise_count_in = diff[RATE_W-1:0];
               endcase
               if (ch_ff == CH_N) begin
                  state_in = ST_HOLD;
               end else begin
                  ch_in    = (ch_ff == CH_A) ? CH_B : CH_N;
                  state_in = ST_MUL;
               end
            end else begin
               // Start the divide of the underflow by the sample rate
               div_rem_in  = '0;
               div_quot_in = '0;
               if (ch_ff == CH_N) begin
                  div_dvd_in = neg_full[DVD_W-1:0] << (DVD_W - NDVD_W);
                  div_cnt_in = DIV_ITER_NOISE;
               end else begin
                  div_dvd_in = neg_full[DVD_W-1:0];
                  div_cnt_in = DIV_ITER_LEVEL;
               end
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            div_rem_in  = div_ge ? div_sub[RATE_W-1:0] : div_tmp[RATE_W-1:0];
            div_dvd_in  = div_dvd_ff << 1;
            div_quot_in = {div_quot_ff[DVD_W-2:0], div_ge};
            div_cnt_in  = div_cnt_ff - 5'd1;
            if (div_cnt_ff == 5'd1) begin
               state_in = ST_APPLY;
            end
         end
         ST_APPLY: begin
            unique case (ch_ff)
               CH_A: begin
                  count_a_in = new_count;
                  level_a_in = lvl_next;
                  ch_in      = CH_B;
                  state_in   = ST_MUL;
               end
               CH_B: begin
                  count_b_in = new_count;
                  level_b_in = lvl_next;
                  ch_in      = CH_N;
                  state_in   = ST_MUL;
               end
               CH_N: begin
                  noise_count_in = new_count;
                  steps_in       = STEPS_W'(div_quot_ff[NDVD_W-1:0]) + 15'd1;
                  state_in       = ST_STEP;
               end
               default: begin
                  state_in = ST_HOLD;
               end
            endcase
         end
         ST_STEP: begin
            shift_in    = sh_step;
            step_idx_in = idx_step;
            steps_in    = steps_ff - 15'd1;
            if (steps_ff == 15'd1) begin
               noise_bit_in = sh_step[0];
               state_in     = ST_HOLD;
            end
         end
         ST_HOLD: begin
            // Signed test: zero or below reloads the hold counter once
            if (hc_dec[31] || hc_dec == '0) begin
               hold_count_in = hc_dec + 32'(sr_eff);
               held_bit_in   = noise_bit_ff;
            end else begin
               hold_count_in = hc_dec;
            end
            state_in = ST_OUT;
         end
         ST_OUT: begin
            // Hold here while the previous sample is still waiting
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_sample_in = out_sum[15:1];
               rsp_valid_in  = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         ch_ff          <= CH_A;
         up_a_ff        <= 1'b0;
         up_b_ff        <= 1'b0;
         level_a_ff     <= '0;
         level_b_ff     <= '0;
         count_a_ff     <= '0;
         count_b_ff     <= '0;
         noise_count_ff <= '0;
         shift_ff       <= '0;
         step_idx_ff    <= '0;
         noise_bit_ff   <= 1'b0;
         held_bit_ff    <= 1'b0;
         hold_count_ff  <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         ch_ff          <= ch_in;
         up_a_ff        <= up_a_in;
         up_b_ff        <= up_b_in;
         level_a_ff     <= level_a_in;
         level_b_ff     <= level_b_in;
         count_a_ff     <= count_a_in;
         count_b_ff     <= count_b_in;
         noise_count_ff <= noise_count_in;
         shift_ff       <= shift_in;
         step_idx_ff    <= step_idx_in;
         noise_bit_ff   <= noise_bit_in;
         held_bit_ff    <= held_bit_in;
         hold_count_ff  <= hold_count_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Shared unit and output payload: no reset needed
   always_ff @(posedge clock) begin
      prod_ff       <= prod_in;
      div_rem_ff    <= div_rem_in;
      div_dvd_ff    <= div_dvd_in;
      div_quot_ff   <= div_quot_in;
      div_cnt_ff    <= div_cnt_in;
      steps_ff      <= steps_in;
      rsp_sample_ff <= rsp_sample_in;
   end

   // Configuration registers: mask the write data to each register's width
   always_ff @(posedge clock) begin
      if (reset) begin
         sample_rate_ff <= RST_SAMPLE_RATE;
         a_dis_rate_ff  <= RST_A_DISCHARGE;
         a_chg_rate_ff  <= RST_A_CHARGE;
         b_chg_rate_ff  <= RST_B_CHARGE;
         b_dis_rate_ff  <= RST_B_DISCHARGE;
         noise_base_ff  <= RST_NOISE_BASE;
         noise_span_ff  <= RST_NOISE_SPAN;
         hold_freq_ff   <= RST_HOLD_FREQ;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_SAMPLE_RATE: sample_rate_ff <= csr_wdata;
            CSR_A_DISCHARGE: a_dis_rate_ff  <= csr_wdata[15:0];
            CSR_A_CHARGE:    a_chg_rate_ff  <= csr_wdata[15:0];
            CSR_B_CHARGE:    b_chg_rate_ff  <= csr_wdata[15:0];
            CSR_B_DISCHARGE: b_dis_rate_ff  <= csr_wdata[15:0];
            CSR_NOISE_BASE:  noise_base_ff  <= csr_wdata[9:0];
            CSR_NOISE_SPAN:  noise_span_ff  <= csr_wdata[12:0];
            CSR_HOLD_FREQ:   hold_freq_ff   <= csr_wdata[12:0];
            default: begin
            end
         endcase
      end
   end

`ifndef SYNTHESIS
   // A new sample appears only out of the output state
   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_OUT))
      else $error("rsp_valid rose outside the output state");

   // Divider remainder stays below the divisor
   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (div_rem_ff < sr_eff))
      else $error("divider remainder not below sample rate");

   // Stepping never runs with an empty step count
   a_steps_live: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_STEP) |-> (steps_ff != '0))
      else $error("noise register stepping with zero count");

   // An accepted request starts the sequencer in the multiply state
   a_req_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_MUL))
      else $error("accepted request did not start the sequencer");
`endif

endmodule

FILE: sim/rc_swept_lfsr_noise_source_unit_test.sv
// Self-checking bench for rc_swept_lfsr_noise_source_unit: drives sample ticks,
// rewrites the rate and coefficient registers between phases and checks every sample.
// Depends on rcsn_pkg and the rtl top level; no files or arguments are read.
`timescale 1ns / 1ps

module rc_swept_lfsr_noise_source_unit_test;
   import rcsn_pkg::*;

   localparam int HALF_PERIOD = 4;
   localparam int CYCLE_LIMIT = 4_000_000;
   localparam int FULL_SCALE  = 32767;
   localparam int N_PROBES    = 18;

   // One row of the directed table: latch byte, whether the sample is typed in,
   // and the typed sample.
   typedef struct packed {
      logic [7:0]  latch;
      logic        typed;
      logic [14:0] sample;
   } probe_row_type;

   logic                clock = 1'b0;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic [7:0]          req_control_latch;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [14:0]         rsp_sample;
   logic                csr_valid;
   logic                csr_ready;
   csr_idx_type         csr_index;
   logic [17:0]         csr_wdata;

   // Register shadow, held at the block's own widths
   logic [17:0] rate_reg;
   logic [15:0] a_dis, a_chg, b_chg, b_dis;
   logic [9:0]  nbase;
   logic [12:0] nspan, hfreq;

   // Shadow of the capacitor levels, pacing counters, noise register and hold
   int          lvl_a, lvl_b;
   longint      cnt_a, cnt_b, cnt_noise;
   logic [31:0] hold_cnt;
   logic [17:0] lfsr, step_idx;
   logic        nbit, hbit;

   // Samples owed by the block, oldest first
   logic [14:0] sample_due [$];

   int req_idle_pct = 10;
   int rsp_idle_pct = 10;
   int error_count = 0;
   int requests_sent = 0;
   int samples_checked = 0;
   int config_sets = 0;
   int lfsr_wraps = 0;
   int cycle_count = 0;

   rc_swept_lfsr_noise_source_unit dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_control_latch (req_control_latch),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_sample        (rsp_sample),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // Watchdog: end the run if the block stops answering.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d samples still owed", cycle_count,
                  sample_due.size());
         $display("tb: failure");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input logic [14:0] got,
                                  input logic [14:0] want);
      error_count++;
      $display("mismatch at cycle %0d: %s: sample %0d, expected %0d", cycle_count, what,
               got, want);
   endtask

   // Subtract dec from a pacing counter; on underflow reload it by whole sample
   // rates and hand back how many reloads that took.
   task automatic pace_counter(inout longint cnt, input longint dec, output longint steps);
      longint sr, c;
      sr = (rate_reg == '0) ? 1 : rate_reg;   // a zero rate counts as one
      c = cnt - dec;
      steps = 0;
      if (c <= 0) begin
         steps = (-c) / sr + 1;
         c = c + steps * sr;
      end
      cnt = c;
   endtask

   // Move one capacitor level toward its rail; nothing happens at the rail.
   task automatic slew_level(inout int lvl, inout longint cnt, input bit up,
                             input longint coef);
      longint rail_gap, steps, v;
      rail_gap = up ? (FULL_SCALE - lvl) : lvl;
      if (rail_gap > 0) begin
         pace_counter(cnt, (coef * rail_gap) >> 8, steps);
         if (steps != 0) begin
            v = up ? lvl + steps : lvl - steps;
            if (v > FULL_SCALE) v = FULL_SCALE;
            if (v < 0) v = 0;
            lvl = int'(v);
         end
      end
   endtask

   // Advance the shadow by one sample tick and return the sample it owes.
   task automatic predict_sample(input logic [7:0] latch, output logic [14:0] smp);
      longint va, vb, mean, freq, steps, k, sum;
      if (latch[LATCH_A_DISCHARGE]) slew_level(lvl_a, cnt_a, 1'b0, a_dis);
      else slew_level(lvl_a, cnt_a, 1'b1, a_chg);
      if (latch[LATCH_B_CHARGE]) slew_level(lvl_b, cnt_b, 1'b1, b_chg);
      else slew_level(lvl_b, cnt_b, 1'b0, b_dis);

      va = FULL_SCALE - lvl_a;
      vb = lvl_b;
      mean = (va + vb) >> 1;
      freq = nbase;
      freq = freq + ((nspan * mean) >> 15);

      // Noise clock: step the XNOR register once per reload, modulo the step counter.
      pace_counter(cnt_noise, freq, steps);
      if (steps > 0) begin
         for (k = steps & 64'h3ffff; k > 0; k--) begin
            lfsr = {lfsr[16:0], lfsr[16] == lfsr[17]};
            step_idx = step_idx + 1'b1;
            if (step_idx == '0) begin
               lfsr = '0;
               lfsr_wraps++;
            end
         end
         nbit = lfsr[0];
      end

      // Sample-and-hold: the counter wraps at 32 bits and reads as signed.
      hold_cnt = hold_cnt - hfreq;
      if ($signed(hold_cnt) <= 0) begin
         hold_cnt = hold_cnt + ((rate_reg == '0) ? 18'd1 : rate_reg);
         hbit = nbit;
      end

      sum = (nbit ? 0 : va) + (hbit ? 0 : vb);
      smp = 15'(sum >> 1);
   endtask

   // Offer one request, holding valid and payload until it is taken, then
   // queue the sample it owes.
   task automatic push_latch(input logic [7:0] latch, input bit typed,
                             input logic [14:0] typed_sample);
      logic [14:0] predicted;
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_control_latch <= latch;
      do @(posedge clock); while (!(req_valid && req_ready));
      predict_sample(latch, predicted);
      sample_due.push_back(typed ? typed_sample : predicted);
      requests_sent++;
   endtask

   task automatic write_reg(input csr_idx_type idx, input logic [17:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      // Mirror the write, truncated to the register's width.
      case (idx)
         CSR_SAMPLE_RATE: rate_reg = value;
         CSR_A_DISCHARGE: a_dis = value[15:0];
         CSR_A_CHARGE:    a_chg = value[15:0];
         CSR_B_CHARGE:    b_chg = value[15:0];
         CSR_B_DISCHARGE: b_dis = value[15:0];
         CSR_NOISE_BASE:  nbase = value[9:0];
         CSR_NOISE_SPAN:  nspan = value[12:0];
         CSR_HOLD_FREQ:   hfreq = value[12:0];
         default: ;
      endcase
   endtask

   // Drain the block, then rewrite all eight registers while it sits idle.
   task automatic program_regs(input logic [17:0] rate, input logic [17:0] adis,
                               input logic [17:0] achg, input logic [17:0] bchg,
                               input logic [17:0] bdis, input logic [17:0] base,
                               input logic [17:0] span, input logic [17:0] hold);
      req_valid <= 1'b0;
      while (sample_due.size() != 0) @(posedge clock);
      write_reg(CSR_SAMPLE_RATE, rate);
      write_reg(CSR_A_DISCHARGE, adis);
      write_reg(CSR_A_CHARGE, achg);
      write_reg(CSR_B_CHARGE, bchg);
      write_reg(CSR_B_DISCHARGE, bdis);
      write_reg(CSR_NOISE_BASE, base);
      write_reg(CSR_NOISE_SPAN, span);
      write_reg(CSR_HOLD_FREQ, hold);
      csr_valid <= 1'b0;
      config_sets++;
   endtask

   // Random ticks shaped as runs that hold one charge/discharge direction for a
   // while, so levels reach their rails and turn back; some items break the run.
   // hot_pct biases runs toward discharging A and charging B (fastest noise clock).
   task automatic random_burst(input int count, input int hot_pct);
      int          run_left;
      int          i;
      logic [1:0]  mode;
      logic [7:0]  latch;
      run_left = 0;
      mode = 2'b00;
      for (i = 0; i < count; i++) begin
         if (run_left == 0) begin
            run_left = $urandom_range(60, 1);
            mode = ($urandom_range(99) < hot_pct) ? 2'b11 : 2'($urandom_range(3));
         end
         run_left--;
         latch = 8'($urandom);
         if ($urandom_range(99) >= 15) latch[LATCH_B_CHARGE:LATCH_A_DISCHARGE] = mode;
         push_latch(latch, 1'b0, '0);
      end
   endtask

   // Directed table. The two ticks right after reset owe a zero sample: the first
   // noise step from an all-zero register sets bit 0, and the hold fires on the
   // first tick and copies it, so both levels are gated off.
   function automatic probe_row_type probe_at(input int i);
      case (i)
         0:  return {8'h00, 1'b1, 15'd0};
         1:  return {8'hff, 1'b1, 15'd0};
         2:  return {8'h40, 1'b0, 15'd0};
         3:  return {8'h80, 1'b0, 15'd0};
         4:  return {8'hc0, 1'b0, 15'd0};
         5:  return {8'h3f, 1'b0, 15'd0};
         6:  return {8'h01, 1'b0, 15'd0};
         7:  return {8'h02, 1'b0, 15'd0};
         8:  return {8'h04, 1'b0, 15'd0};
         9:  return {8'h08, 1'b0, 15'd0};
         10: return {8'h10, 1'b0, 15'd0};
         11: return {8'h20, 1'b0, 15'd0};
         12: return {8'hbf, 1'b0, 15'd0};
         13: return {8'h7f, 1'b0, 15'd0};
         14: return {8'h55, 1'b0, 15'd0};
         15: return {8'haa, 1'b0, 15'd0};
         16: return {8'hfe, 1'b0, 15'd0};
         default: return {8'h00, 1'b0, 15'd0};
      endcase
   endfunction

   // Compare every sample taken by the receiver with the oldest one owed.
   always @(posedge clock) begin : rsp_check
      logic [14:0] want;
      if (!reset && rsp_valid && rsp_ready) begin
         samples_checked++;
         if (sample_due.size() == 0)
            report_mismatch("sample with no request outstanding", rsp_sample, '0);
         else begin
            want = sample_due.pop_front();
            if (rsp_sample !== want) report_mismatch("wrong sample", rsp_sample, want);
         end
      end
   end

   // Receiver: drop ready at random, and once hold it low for a long stretch so
   // the output register fills and the block stops taking requests.
   initial begin : rsp_sink
      int taken;
      int stall_left;
      bit squeezed;
      taken = 0;
      stall_left = 0;
      squeezed = 1'b0;
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) taken++;
         if (!squeezed && taken == 120) begin
            squeezed = 1'b1;
            stall_left = 400;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else
            rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   initial begin : stimulus
      probe_row_type row;
      int            i;

      // Hold every input at a known value and load the shadow's reset state.
      reset = 1'b1;
      req_valid = 1'b0;
      req_control_latch = '0;
      csr_valid = 1'b0;
      csr_index = CSR_SAMPLE_RATE;
      csr_wdata = '0;
      rate_reg = RST_SAMPLE_RATE;
      a_dis = RST_A_DISCHARGE;
      a_chg = RST_A_CHARGE;
      b_chg = RST_B_CHARGE;
      b_dis = RST_B_DISCHARGE;
      nbase = RST_NOISE_BASE;
      nspan = RST_NOISE_SPAN;
      hfreq = RST_HOLD_FREQ;
      lvl_a = 0;
      lvl_b = 0;
      cnt_a = 0;
      cnt_b = 0;
      cnt_noise = 0;
      hold_cnt = '0;
      lfsr = '0;
      step_idx = '0;
      nbit = 1'b0;
      hbit = 1'b0;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed ticks at the reset register values: every latch bit alone,
      // all four direction pairs and the all-zero and all-one bytes.
      for (i = 0; i < N_PROBES; i++) begin
         row = probe_at(i);
         push_latch(row.latch, row.typed, row.sample);
      end

      // Reset values written back explicitly; the long receiver hold-off lands here.
      program_regs(RST_SAMPLE_RATE, RST_A_DISCHARGE, RST_A_CHARGE, RST_B_CHARGE,
                   RST_B_DISCHARGE, RST_NOISE_BASE, RST_NOISE_SPAN, RST_HOLD_FREQ);
      random_burst(300, 0);

      // All-ones write: every register saturates at its width.
      program_regs('1, '1, '1, '1, '1, '1, '1, '1);
      random_burst(200, 0);

      // All zero: rate taken as one, levels frozen, noise clock stopped.
      program_regs('0, '0, '0, '0, '0, '0, '0, '0);
      random_burst(100, 0);

      // Lowest normal rate with the hold rate above it, so the hold counter
      // drifts down; no idling on either side through this stretch.
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      program_regs(18'd8000, 18'($urandom_range(65535)), 18'($urandom_range(65535)),
                   18'($urandom_range(65535)), 18'($urandom_range(65535)),
                   18'($urandom_range(1000)), 18'd6999, 18'd8191);
      random_burst(250, 0);
      req_idle_pct = 10;
      rsp_idle_pct = 10;

      // Zero rate with the fastest noise clock: thousands of register steps per
      // tick, enough to wrap the step counter and restart the register.
      program_regs('0, 18'($urandom_range(65535)), 18'($urandom_range(65535)),
                   18'($urandom_range(65535)), 18'($urandom_range(65535)),
                   '1, '1, '1);
      random_burst(48, 90);

      // Random settings over the normal ranges.
      for (i = 0; i < 4; i++) begin
         program_regs(18'($urandom_range(192000, 8000)), 18'($urandom_range(65535)),
                      18'($urandom_range(65535)), 18'($urandom_range(65535)),
                      18'($urandom_range(65535)), 18'($urandom_range(1000)),
                      18'($urandom_range(6999)), 18'($urandom_range(7999)));
         random_burst(215, 0);
      end

      // Drain, then leave room for anything stray to show up.
      req_valid <= 1'b0;
      while (sample_due.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);

      $display("summary: %0d ticks over %0d register settings, %0d samples compared",
               requests_sent, config_sets, samples_checked);
      $display("summary: %0d noise step-counter wraps, %0d mismatches", lfsr_wraps,
               error_count);
      if (error_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
